>>> hdl/drlt_pkg.sv
// ----------------------------------------------------------------------------
// drlt_pkg - shared types and geometry for the dirty rectangle list tracker
// Item and result layouts, op codes, controller/datapath handshake structs
// and the rectangle contain / overlap / union helpers.
// ----------------------------------------------------------------------------
package drlt_pkg;

    // default list depth and fixed field widths
    localparam int MAX_RECTS_DEF = 20;
    localparam int COUNT_W       = 7;
    localparam logic [14:0] DIM_MAX = 15'h7FFF;

    // op codes; the fourth code changes nothing
    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    // one stored rectangle
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
    } t_rect;

    // input item
    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic [14:0]        rect_w;
        logic [14:0]        rect_h;
        logic [5:0]         entry_index;
    } t_item;

    // result item
    typedef struct packed {
        logic [COUNT_W-1:0] entry_count;
        logic signed [15:0] bound_x;
        logic signed [15:0] bound_y;
        logic [14:0]        bound_w;
        logic [14:0]        bound_h;
        logic signed [15:0] entry_x;
        logic signed [15:0] entry_y;
        logic [14:0]        entry_w;
        logic [14:0]        entry_h;
        logic               entry_valid;
    } t_res;

    // controller to datapath commands
    typedef struct packed {
        logic load;        // latch the item, clear the entry result
        logic clr_count;   // empty the list
        logic first;       // store entry 0 and bounds, count becomes one
        logic bound_grow;  // bounds to union, start walk at entry 0
        logic idx_inc;     // move walk to next entry
        logic wr_new;      // write the new rectangle
        logic wr_union;    // write union of walked entry and new rectangle
        logic wr_tail;     // write address is the current count
        logic cnt_inc;     // one more entry
        logic ent_cap;     // capture read entry
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic empty;
        logic full;
        logic last;
        logic hit_in;      // walked entry contains new rectangle
        logic hit_cov;     // new rectangle contains walked entry
        logic hit_ovl;     // positive-area overlap
    } t_status;

    // right or bottom edge, exclusive
    function automatic logic signed [16:0] far_side(logic signed [15:0] p, logic [14:0] s);
        return 17'(p) + $signed({2'b00, s});
    endfunction

    // a contains b, equal edges included
    function automatic logic rect_contains(t_rect a, t_rect b);
        return (b.x >= a.x) && (b.y >= a.y) &&
               (far_side(b.x, b.w) <= far_side(a.x, a.w)) &&
               (far_side(b.y, b.h) <= far_side(a.y, a.h));
    endfunction

    // positive area in both directions
    function automatic logic rect_overlaps(t_rect a, t_rect b);
        logic signed [15:0] l;
        logic signed [15:0] t;
        logic signed [16:0] r;
        logic signed [16:0] d;
        logic signed [16:0] ar;
        logic signed [16:0] br;
        logic signed [16:0] ad;
        logic signed [16:0] bd;
        ar = far_side(a.x, a.w);
        br = far_side(b.x, b.w);
        ad = far_side(a.y, a.h);
        bd = far_side(b.y, b.h);
        l  = (a.x > b.x) ? a.x : b.x;
        t  = (a.y > b.y) ? a.y : b.y;
        r  = (ar < br) ? ar : br;
        d  = (ad < bd) ? ad : bd;
        return (17'(l) < r) && (17'(t) < d);
    endfunction

    // bounding union, size saturates
    function automatic t_rect rect_union(t_rect a, t_rect b);
        logic signed [16:0] ar;
        logic signed [16:0] br;
        logic signed [16:0] ad;
        logic signed [16:0] bd;
        logic signed [16:0] r;
        logic signed [16:0] d;
        logic signed [17:0] w;
        logic signed [17:0] h;
        t_rect u;
        ar  = far_side(a.x, a.w);
        br  = far_side(b.x, b.w);
        ad  = far_side(a.y, a.h);
        bd  = far_side(b.y, b.h);
        r   = (ar > br) ? ar : br;
        d   = (ad > bd) ? ad : bd;
        u.x = (a.x < b.x) ? a.x : b.x;
        u.y = (a.y < b.y) ? a.y : b.y;
        w   = 18'(r) - 18'(u.x);
        h   = 18'(d) - 18'(u.y);
        u.w = (w > 18'sd32767) ? DIM_MAX : w[14:0];
        u.h = (h > 18'sd32767) ? DIM_MAX : h[14:0];
        return u;
    endfunction

endpackage

>>> hdl/dirty_rect_list_tracker.sv
// ----------------------------------------------------------------------------
// dirty_rect_list_tracker - bounded list of damaged rectangles
// Records damage rectangles with merging and keeps their bounding box.
//
// Usage: present an item on i_item and raise start; it is taken at a clock
// edge where start is high and busy is low. Ops: add a rectangle, clear the
// list, read one entry. Every item gives exactly one result on o_result,
// marked by o_valid for a single cycle; the receiver cannot stall it.
// Clear and the unused op answer in the cycle after they are taken; a read
// passes through the readout state, an add into an empty list through the
// first-entry state, and any other add through the bounds-grow state and
// then the walk, which ends at the first matching entry or the last one. The
// walk reads one entry a cycle from the single read port of the entry store.
// A new item may be started in the cycle its result is shown.
// Reset empties the list and zeroes the bounds; the store itself needs no
// clearing pass.
// ----------------------------------------------------------------------------
module dirty_rect_list_tracker #(
    parameter int MAX_RECTS = drlt_pkg::MAX_RECTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  drlt_pkg::t_item i_item,
    output logic            o_valid,
    output drlt_pkg::t_res  o_result
);
    import drlt_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer
    drlt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_op     (i_item.op),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_done   (o_valid)
    );

    // datapath and entry store
    drlt_dpath #(
        .MAX_RECTS (MAX_RECTS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_status (status),
        .o_res    (o_result)
    );

endmodule

>>> hdl/drlt_ram.sv
// ----------------------------------------------------------------------------
// drlt_ram - generic simple dual-port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module drlt_ram #(
    parameter int WIDTH  = 62,
    parameter int DEPTH  = 20,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/drlt_ctrl.sv
// ----------------------------------------------------------------------------
// drlt_ctrl - sequencer for the dirty rectangle list tracker
// Dispatches items, walks the list one entry a cycle and strobes the result.
// ----------------------------------------------------------------------------
module drlt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_op,
    input  drlt_pkg::t_status i_status,
    output drlt_pkg::t_cmd    o_cmd,
    output logic              o_busy,
    output logic              o_done
);
    import drlt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_GROW,
        S_WALK,
        S_RDOUT
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;
    t_cmd   cmd;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    unique case (i_op)
                        OP_ADD:   n_state = i_status.empty ? S_FIRST : S_GROW;
                        OP_CLEAR: begin
                            cmd.clr_count = 1'b1;
                            n_done        = 1'b1;
                        end
                        OP_READ:  n_state = S_RDOUT;
                        default:  n_done = 1'b1;
                    endcase
                end
            end
            S_FIRST: begin
                cmd.first = 1'b1;
                n_state   = S_IDLE;
                n_done    = 1'b1;
            end
            S_GROW: begin
                cmd.bound_grow = 1'b1;
                n_state        = S_WALK;
            end
            S_WALK: begin
                // first matching entry decides
                priority if (i_status.hit_in) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end else if (i_status.hit_cov) begin
                    cmd.wr_new = 1'b1;
                    n_state    = S_IDLE;
                    n_done     = 1'b1;
                end else if (i_status.hit_ovl) begin
                    cmd.wr_union = 1'b1;
                    n_state      = S_IDLE;
                    n_done       = 1'b1;
                end else if (i_status.last) begin
                    // no match: merge into last entry or append
                    if (i_status.full) begin
                        cmd.wr_union = 1'b1;
                    end else begin
                        cmd.wr_new  = 1'b1;
                        cmd.wr_tail = 1'b1;
                        cmd.cnt_inc = 1'b1;
                    end
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_RDOUT: begin
                cmd.ent_cap = 1'b1;
                n_state     = S_IDLE;
                n_done      = 1'b1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

>>> hdl/drlt_dpath.sv
// ----------------------------------------------------------------------------
// drlt_dpath - datapath for the dirty rectangle list tracker
// Holds the new rectangle, count, bounds, walk index and read result, and
// evaluates one stored entry a cycle against the new rectangle.
// ----------------------------------------------------------------------------
module drlt_dpath #(
    parameter int MAX_RECTS = drlt_pkg::MAX_RECTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  drlt_pkg::t_item   i_item,
    input  drlt_pkg::t_cmd    i_cmd,
    output drlt_pkg::t_status o_status,
    output drlt_pkg::t_res    o_res
);
    import drlt_pkg::*;

    localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CW = $clog2(MAX_RECTS + 1);
    localparam int RW = $bits(t_rect);

    t_rect           r_new;
    t_rect           r_bound;
    t_rect           r_ent;
    logic            r_ent_valid;
    logic            r_rd_ok;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   r_idx;

    logic [RW-1:0]   rd_data;
    t_rect           walk_ent;
    t_rect           merged;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    t_rect           ram_wdata;
    logic            index_ok;

    assign walk_ent = t_rect'(rd_data);
    assign merged   = rect_union(walk_ent, r_new);
    assign index_ok = ({1'b0, i_item.entry_index} < COUNT_W'(r_count));

    // entry store
    assign ram_we    = i_cmd.first | i_cmd.wr_new | i_cmd.wr_union;
    assign ram_wdata = i_cmd.wr_union ? merged : r_new;

    always_comb begin
        priority if (i_cmd.first) begin
            ram_waddr = '0;
        end else if (i_cmd.wr_tail) begin
            ram_waddr = r_count[AW-1:0];
        end else begin
            ram_waddr = r_idx;
        end
    end

    // read the asked entry at dispatch, entry 0 as the walk starts, else prefetch the next walk entry
    always_comb begin
        priority if (i_cmd.load) begin
            ram_raddr = i_item.entry_index[AW-1:0];
        end else if (i_cmd.bound_grow) begin
            ram_raddr = '0;
        end else begin
            ram_raddr = r_idx + 1'b1;
        end
    end

    drlt_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_RECTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    // count, bounds and walk index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_bound <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.clr_count) begin
                r_count <= '0;
            end else if (i_cmd.first) begin
                r_count <= CW'(1);
            end else if (i_cmd.cnt_inc) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.first) begin
                r_bound <= r_new;
            end else if (i_cmd.bound_grow) begin
                r_bound <= rect_union(r_bound, r_new);
            end
            if (i_cmd.bound_grow) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // item latch and read result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_new.x     <= i_item.rect_x;
            r_new.y     <= i_item.rect_y;
            r_new.w     <= i_item.rect_w;
            r_new.h     <= i_item.rect_h;
            r_rd_ok     <= index_ok;
            r_ent       <= '0;
            r_ent_valid <= 1'b0;
        end else if (i_cmd.ent_cap) begin
            r_ent       <= r_rd_ok ? walk_ent : '0;
            r_ent_valid <= r_rd_ok;
        end
    end

    // status to the sequencer
    assign o_status.empty   = (r_count == '0);
    assign o_status.full    = (r_count == CW'(MAX_RECTS));
    assign o_status.last    = ((CW'(r_idx) + CW'(1)) == r_count);
    assign o_status.hit_in  = rect_contains(walk_ent, r_new);
    assign o_status.hit_cov = rect_contains(r_new, walk_ent);
    assign o_status.hit_ovl = rect_overlaps(r_new, walk_ent);

    // result item
    assign o_res.entry_count = COUNT_W'(r_count);
    assign o_res.bound_x     = r_bound.x;
    assign o_res.bound_y     = r_bound.y;
    assign o_res.bound_w     = r_bound.w;
    assign o_res.bound_h     = r_bound.h;
    assign o_res.entry_x     = r_ent.x;
    assign o_res.entry_y     = r_ent.y;
    assign o_res.entry_w     = r_ent.w;
    assign o_res.entry_h     = r_ent.h;
    assign o_res.entry_valid = r_ent_valid;

endmodule

>>> hdl/drlt_checker.sv
// ----------------------------------------------------------------------------
// drlt_checker - port-level checks for the dirty rectangle list tracker
// Watches the item and result channels, bound to the top level.
// ----------------------------------------------------------------------------
module drlt_checker #(
    parameter int MAX_RECTS = drlt_pkg::MAX_RECTS_DEF
) (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input logic            busy,
    input drlt_pkg::t_item i_item,
    input logic            o_valid,
    input drlt_pkg::t_res  o_result
);
    import drlt_pkg::*;

    // a taken item is either still in work or answered next cycle
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_valid)
        else $error("item taken but neither busy nor answered");

    // no result without an item in flight
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && !start |=> !o_valid)
        else $error("result strobe with no item in flight");

    // count never exceeds the list depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.entry_count <= COUNT_W'(MAX_RECTS))
        else $error("entry count beyond list depth");

    // a valid read needs a non-empty list
    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.entry_valid |-> o_result.entry_count != '0)
        else $error("valid entry read from an empty list");

endmodule

bind dirty_rect_list_tracker drlt_checker #(.MAX_RECTS(MAX_RECTS)) u_checker (.*);

>>> tb/dirty_rect_list_tracker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dirty_rect_list_tracker_test - self-checking bench for the damage list
// Drives add, clear, read and spare-op items through the command handshake.
// Every result is checked against an in-bench model of the rectangle list.
// A directed opener hits the edge cases, then random scenes follow: grid
// placed rectangles, rectangles built around stored entries, full-range
// values and coordinate extremes. Sender idling varies from phase to phase,
// and the bench drains all results between phases.
// ----------------------------------------------------------------------------
module dirty_rect_list_tracker_test;
    import drlt_pkg::*;

    localparam int DEPTH = MAX_RECTS_DEF;
    localparam logic [1:0] OP_SPARE = 2'd3;   // unused op code, changes nothing
    localparam int SHOWN_MAX = 20;            // mismatch lines printed at most

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    t_item i_item  = '0;
    logic  busy;
    logic  o_valid;
    t_res  o_result;

    int phase_idle [5] = '{0, 55, 24, 0, 24};

    // model of the list, expected results and mismatch bookkeeping
    class rect_list_scoreboard;
        t_rect store [DEPTH];
        int    count;
        t_rect bounds;
        t_res  expected_q [$];
        int    errors;
        int    n_add;
        int    n_clear;
        int    n_read;
        int    n_spare;
        int    n_checked;
        int    n_tail_merge;
        int    peak;

        function new();
            bounds = '0;
        endfunction

        function int far_x(t_rect r);
            return int'(r.x) + int'(r.w);
        endfunction

        function int far_y(t_rect r);
            return int'(r.y) + int'(r.h);
        endfunction

        // a holds b, shared edges allowed
        function bit encloses(t_rect a, t_rect b);
            return (b.x >= a.x) && (b.y >= a.y) &&
                   (far_x(b) <= far_x(a)) && (far_y(b) <= far_y(a));
        endfunction

        // positive area in common
        function bit intersects(t_rect a, t_rect b);
            int l;
            int t;
            int r;
            int d;
            l = (a.x > b.x) ? a.x : b.x;
            t = (a.y > b.y) ? a.y : b.y;
            r = (far_x(a) < far_x(b)) ? far_x(a) : far_x(b);
            d = (far_y(a) < far_y(b)) ? far_y(a) : far_y(b);
            return (l < r) && (t < d);
        endfunction

        // bounding box of both, sizes held at the 15-bit maximum
        function t_rect merged(t_rect a, t_rect b);
            t_rect u;
            int    r;
            int    d;
            int    w;
            int    h;
            r   = (far_x(a) > far_x(b)) ? far_x(a) : far_x(b);
            d   = (far_y(a) > far_y(b)) ? far_y(a) : far_y(b);
            u.x = (a.x < b.x) ? a.x : b.x;
            u.y = (a.y < b.y) ? a.y : b.y;
            w   = r - int'(u.x);
            h   = d - int'(u.y);
            if (w > int'(DIM_MAX)) w = int'(DIM_MAX);
            if (h > int'(DIM_MAX)) h = int'(DIM_MAX);
            u.w = 15'(w);
            u.h = 15'(h);
            return u;
        endfunction

        // first matching entry decides, else append or fold into the tail
        function void record_damage(t_rect n);
            if (count == 0) begin
                store[0] = n;
                bounds   = n;
                count    = 1;
                return;
            end
            bounds = merged(bounds, n);
            for (int i = 0; i < count; i++) begin
                if (encloses(store[i], n)) return;
                if (encloses(n, store[i])) begin
                    store[i] = n;
                    return;
                end
                if (intersects(n, store[i])) begin
                    store[i] = merged(store[i], n);
                    return;
                end
            end
            if (count >= DEPTH) begin
                store[DEPTH-1] = merged(store[DEPTH-1], n);
                n_tail_merge++;
            end else begin
                store[count] = n;
                count++;
            end
        endfunction

        // accepted item: advance the model and queue its result
        function void note_item(t_item it);
            t_res  want;
            t_rect n;
            want = '0;
            case (it.op)
                OP_ADD: begin
                    n.x = it.rect_x;
                    n.y = it.rect_y;
                    n.w = it.rect_w;
                    n.h = it.rect_h;
                    record_damage(n);
                    n_add++;
                end
                OP_CLEAR: begin
                    count = 0;
                    n_clear++;
                end
                OP_READ: begin
                    if (int'(it.entry_index) < count) begin
                        want.entry_x     = store[it.entry_index].x;
                        want.entry_y     = store[it.entry_index].y;
                        want.entry_w     = store[it.entry_index].w;
                        want.entry_h     = store[it.entry_index].h;
                        want.entry_valid = 1'b1;
                    end
                    n_read++;
                end
                default: n_spare++;
            endcase
            if (count > peak) peak = count;
            want.entry_count = 7'(count);
            want.bound_x     = bounds.x;
            want.bound_y     = bounds.y;
            want.bound_w     = bounds.w;
            want.bound_h     = bounds.h;
            expected_q.push_back(want);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string what);
            errors++;
            if (errors <= SHOWN_MAX)
                $display("mismatch at result %0d: %s", n_checked, what);
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("%s is %0h, expected %0h", name, got, want));
        endtask

        // one result from the block against the oldest expectation
        task check_result(t_res got);
            t_res want;
            n_checked++;
            if (expected_q.size() == 0) begin
                report("result with no item waiting");
                return;
            end
            want = expected_q.pop_front();
            compare_field("entry_count", got.entry_count, want.entry_count);
            compare_field("bound_x", got.bound_x, want.bound_x);
            compare_field("bound_y", got.bound_y, want.bound_y);
            compare_field("bound_w", got.bound_w, want.bound_w);
            compare_field("bound_h", got.bound_h, want.bound_h);
            compare_field("entry_x", got.entry_x, want.entry_x);
            compare_field("entry_y", got.entry_y, want.entry_y);
            compare_field("entry_w", got.entry_w, want.entry_w);
            compare_field("entry_h", got.entry_h, want.entry_h);
            compare_field("entry_valid", got.entry_valid, want.entry_valid);
        endtask
    endclass

    rect_list_scoreboard sb = new();

    dirty_rect_list_tracker #(
        .MAX_RECTS(DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    always #6 i_clk = ~i_clk;

    // every strobed result is checked at the edge that ends it
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result(o_result);
    end

    function automatic int clip(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic t_item make_item(logic [1:0] op, int x, int y, int w, int h,
                                        int idx);
        t_item it;
        it.op          = op;
        it.rect_x      = 16'(x);
        it.rect_y      = 16'(y);
        it.rect_w      = 15'(w);
        it.rect_h      = 15'(h);
        it.entry_index = 6'(idx);
        return it;
    endfunction

    // damage rectangle for a random add, shaped to hit every match kind
    function automatic t_rect pick_rect();
        t_rect e;
        t_rect n;
        int    kind;
        int    tile;
        int    ex;
        int    ey;
        int    ew;
        int    eh;
        int    d;
        int    x;
        int    y;
        int    w;
        int    h;
        kind = $urandom_range(99);
        if (kind < 35 || (kind < 60 && sb.count == 0)) begin
            // grid tiles: disjoint across tiles, able to overlap within one
            tile = $urandom_range(63);
            x = (tile % 8) * 600 - 2400 + int'($urandom_range(150));
            y = (tile / 8) * 600 - 2400 + int'($urandom_range(150));
            w = $urandom_range(400);
            h = $urandom_range(400);
        end else if (kind < 60) begin
            // built around a stored entry
            e  = sb.store[$urandom_range(sb.count - 1)];
            ex = e.x;
            ey = e.y;
            ew = e.w;
            eh = e.h;
            case ($urandom_range(3))
                0: begin
                    x = ex + int'($urandom_range(ew));
                    y = ey + int'($urandom_range(eh));
                    w = $urandom_range(ex + ew - x);
                    h = $urandom_range(ey + eh - y);
                end
                1: begin
                    d = $urandom_range(40);
                    x = ex - d;
                    w = ew + d + int'($urandom_range(40));
                    d = $urandom_range(40);
                    y = ey - d;
                    h = eh + d + int'($urandom_range(40));
                end
                2: begin
                    x = ex + int'($urandom_range(ew)) - 30;
                    y = ey + int'($urandom_range(eh)) - 30;
                    w = 1 + int'($urandom_range(300));
                    h = 1 + int'($urandom_range(300));
                end
                default: begin
                    // shares the right edge only
                    x = ex + ew;
                    y = ey;
                    w = $urandom_range(60);
                    h = eh;
                end
            endcase
        end else if (kind < 82) begin
            x = int'($urandom_range(65535)) - 32768;
            y = int'($urandom_range(65535)) - 32768;
            w = $urandom_range(32767);
            h = $urandom_range(32767);
        end else begin
            // coordinate and size extremes
            case ($urandom_range(3))
                0: x = -32768;
                1: x = 32767;
                2: x = -1;
                default: x = 0;
            endcase
            case ($urandom_range(3))
                0: y = -32768;
                1: y = 32767;
                2: y = -1;
                default: y = 0;
            endcase
            w = ($urandom_range(1) != 0) ? 32767 : int'($urandom_range(1));
            h = ($urandom_range(1) != 0) ? 32767 : int'($urandom_range(1));
        end
        n.x = 16'(clip(x, -32768, 32767));
        n.y = 16'(clip(y, -32768, 32767));
        n.w = 15'(clip(w, 0, 32767));
        n.h = 15'(clip(h, 0, 32767));
        return n;
    endfunction

    // random item: mostly adds and reads, rare clears and spare ops
    function automatic t_item random_item();
        t_item it;
        t_rect n;
        int    r;
        r  = $urandom_range(99);
        it = make_item(OP_READ, int'($urandom_range(65535)) - 32768,
                       int'($urandom_range(65535)) - 32768, $urandom_range(32767),
                       $urandom_range(32767), $urandom_range(63));
        if (r < 60 || r >= 95) begin
            n         = pick_rect();
            it.op     = OP_ADD;
            it.rect_x = n.x;
            it.rect_y = n.y;
            it.rect_w = n.w;
            it.rect_h = n.h;
        end else if (r < 90) begin
            it.op = OP_READ;
            if ($urandom_range(3) != 0)
                it.entry_index = 6'($urandom_range(sb.count + 1));
        end else if (r < 92) begin
            it.op = OP_CLEAR;
        end else begin
            it.op = OP_SPARE;
        end
        return it;
    endfunction

    // present one item after a random idle gap; start stays high on return
    task automatic send(t_item it, int idle_pct);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_item(it);
    endtask

    // hold off until every result is in, then let the block settle
    task automatic drain();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (sb.pending() != 0 && waited < 20 * DEPTH + 200) begin
            @(posedge i_clk);
            waited++;
        end
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        repeat (DEPTH + 4) @(posedge i_clk);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed opener
        send(make_item(OP_READ, 0, 0, 0, 0, 0), 0);                 // read on empty list
        send(make_item(OP_SPARE, -1, -1, 32767, 32767, 63), 0);
        send(make_item(OP_ADD, -32768, -32768, 0, 0, 0), 0);        // first entry, zero size
        send(make_item(OP_ADD, 32767, 32767, 32767, 32767, 0), 0);  // bounds saturate
        send(make_item(OP_ADD, 32767, 32767, 1, 1, 0), 0);          // held by an entry
        send(make_item(OP_ADD, -32768, -32768, 100, 100, 0), 0);    // swallows entry 0
        send(make_item(OP_ADD, -32700, -32700, 32767, 32767, 0), 0); // overlap, saturating
        send(make_item(OP_ADD, -1, -32768, 10, 10, 0), 0);          // edge contact only
        send(make_item(OP_ADD, 9, -32758, 0, 0, 0), 0);             // point on a corner
        for (int i = 0; i < 4; i++)
            send(make_item(OP_READ, 0, 0, 0, 0, i), 0);             // last is past the end
        send(make_item(OP_READ, 0, 0, 0, 0, 63), 0);
        send(make_item(OP_CLEAR, 0, 0, 0, 0, 0), 0);
        send(make_item(OP_READ, 0, 0, 0, 0, 0), 0);                 // bounds kept after clear
        send(make_item(OP_ADD, 10, 20, 30, 40, 0), 0);              // bounds overwritten
        send(make_item(OP_SPARE, 0, 0, 0, 0, 0), 0);
        send(make_item(OP_READ, 0, 0, 0, 0, 0), 0);
        drain();

        // random phases with varying sender idling, drained in between
        for (int p = 0; p < 5; p++) begin
            repeat (90) send(random_item(), phase_idle[p]);
            drain();
        end

        $display("run covered %0d adds, %0d clears, %0d reads, %0d spare-op items",
                 sb.n_add, sb.n_clear, sb.n_read, sb.n_spare);
        $display("%0d results checked, longest list %0d, %0d folds into a full list tail",
                 sb.n_checked, sb.peak, sb.n_tail_merge);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // overall watchdog
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
